### rtl/mvt_pkg.sv
// Shared types, constants and helper functions for the matrix-vector transform.
package mvt_pkg;

   localparam int DIM         = 4;
   localparam int NUM_REGS    = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int COEF_W      = 32;
   localparam int PROD_W      = 2 * COEF_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int FRAC_W      = 16;
   localparam int CELL_STAGES = 2;
   localparam int LATENCY     = DIM * CELL_STAGES + 1;

   localparam logic [COEF_W-1:0] Q16_ONE = COEF_W'(32'h0001_0000);
   localparam logic [COEF_W-1:0] Q16_MAX = COEF_W'(32'h7FFF_FFFF);
   localparam logic [COEF_W-1:0] Q16_MIN = COEF_W'(32'h8000_0000);

   typedef logic signed [COEF_W-1:0] q16_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // One word as it walks down the cell chain: the vector and the running row sums.
   typedef struct packed {
      q16_type [DIM-1:0] vec;
      acc_type [DIM-1:0] sum;
   } lane_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_wr_type;

   // Identity matrix after reset.
   function automatic q16_type coef_reset(input int row, input int col);
      q16_type res;
      res = (row == col) ? q16_type'(Q16_ONE) : '0;
      return res;
   endfunction

   // Shift right by the fraction width and clamp to the 32-bit range.
   function automatic q16_type sat_q16(input acc_type s);
      logic [ACC_W-FRAC_W-COEF_W:0] top_bits;
      q16_type                      res;
      top_bits = s[ACC_W-1:FRAC_W+COEF_W-1];
      if ((top_bits == '0) || (top_bits == '1)) begin
         res = s[FRAC_W+COEF_W-1:FRAC_W];
      end else if (s[ACC_W-1]) begin
         res = Q16_MIN;
      end else begin
         res = Q16_MAX;
      end
      return res;
   endfunction

endpackage

### rtl/mvt_cell.sv
// One column cell: holds one matrix column, multiplies and accumulates into the row sums.
module mvt_cell #(
   parameter int COL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  mvt_pkg::csr_wr_type csr_wr,
   input  logic                in_valid,
   output logic                in_stall,
   input  mvt_pkg::lane_type   in_lane,
   output logic                out_valid,
   input  logic                out_stall,
   output mvt_pkg::lane_type   out_lane
);
   import mvt_pkg::*;

   localparam logic [1:0] COL_SEL = 2'(COL_IDX);

   q16_type  coef_ff [DIM];
   q16_type  coef_in [DIM];
   prod_type prod_ff [DIM];
   prod_type prod_in [DIM];
   lane_type lane1_ff;
   lane_type lane2_ff;
   lane_type lane2_in;
   logic     valid1_ff;
   logic     valid1_in;
   logic     valid2_ff;
   logic     valid2_in;
   logic     en1;
   logic     en2;
   logic     csr_hit;
   logic [1:0] csr_row;
   q16_type  csr_coef;
   q16_type  vec_c;

   // Advance a stage when it is empty or the next one moves.
   assign en2       = !valid2_ff || !out_stall;
   assign en1       = !valid1_ff || en2;
   assign in_stall  = !en1;
   assign valid1_in = en1 ? in_valid : valid1_ff;
   assign valid2_in = en2 ? valid1_ff : valid2_ff;

   assign csr_hit  = csr_wr.we && (csr_wr.index < CSR_INDEX_W'(NUM_REGS))
                     && (csr_wr.index[0] == COL_SEL[1]);
   assign csr_row  = csr_wr.index[2:1];
   assign csr_coef = COL_SEL[0] ? csr_wr.data[COEF_W-1:0] : csr_wr.data[CSR_DATA_W-1:COEF_W];

   always_comb begin
      coef_in = coef_ff;
      if (csr_hit) begin
         coef_in[csr_row] = csr_coef;
      end
   end

   assign vec_c = in_lane.vec[COL_IDX];

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         prod_in[r] = coef_ff[r] * vec_c;
      end
   end

   always_comb begin
      lane2_in = lane1_ff;
      for (int r = 0; r < DIM; r++) begin
         lane2_in.sum[r] = lane1_ff.sum[r] + ACC_W'(prod_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         for (int r = 0; r < DIM; r++) begin
            coef_ff[r] <= coef_reset(r, COL_IDX);
         end
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         coef_ff   <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         lane1_ff <= in_lane;
         prod_ff  <= prod_in;
      end
      if (en2) begin
         lane2_ff <= lane2_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_lane  = lane2_ff;

endmodule

### rtl/mvt_sat.sv
// Output stage: scale and clamp the row sums and hold the result word.
module mvt_sat (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  mvt_pkg::lane_type            in_lane,
   output logic                         out_valid,
   input  logic                         out_stall,
   output mvt_pkg::q16_type [mvt_pkg::DIM-1:0] out_vec
);
   import mvt_pkg::*;

   q16_type [DIM-1:0] res_ff;
   q16_type [DIM-1:0] res_in;
   logic              valid_ff;
   logic              valid_in;
   logic              en;

   assign en       = !valid_ff || !out_stall;
   assign in_stall = !en;
   assign valid_in = en ? in_valid : valid_ff;

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         res_in[r] = sat_q16(in_lane.sum[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = res_ff;

endmodule

### rtl/matrix_vector_transform.sv
// Top level of the 4x4 matrix times vector transform in signed Q16.16.
//
//   Port group   Direction  Handshake          Contents
//   req_*        in         valid / stall      vector x, y, z, w (Q16.16)
//   rsp_*        out        valid / stall      row dot products x, y, z, w (Q16.16)
//   csr_*        in         write enable only  8 x 64-bit matrix registers
//
// One word is accepted per cycle while req is not stalled, and each word passes through
// four column cells of two stages each (multiply, then accumulate) and one clamp stage.
// Synchronous reset clears all valid bits and loads the identity matrix.
// A stall on rsp holds the result word; empty stages still close up behind it, so
// req only stalls once every stage holds a word and rsp is stalled.
module matrix_vector_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   // input vectors
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mvt_pkg::q16_type                      req_vec_x,
   input  mvt_pkg::q16_type                      req_vec_y,
   input  mvt_pkg::q16_type                      req_vec_z,
   input  mvt_pkg::q16_type                      req_vec_w,
   // transformed vectors
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mvt_pkg::q16_type                      rsp_out_x,
   output mvt_pkg::q16_type                      rsp_out_y,
   output mvt_pkg::q16_type                      rsp_out_z,
   output mvt_pkg::q16_type                      rsp_out_w,
   // matrix registers
   input  logic                                  csr_we,
   input  logic [mvt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mvt_pkg::CSR_DATA_W-1:0]        csr_data
);
   import mvt_pkg::*;

   // Chain links: link k feeds cell k, link DIM feeds the clamp stage.
   lane_type          lane  [DIM+1];
   logic              valid [DIM+1];
   logic              stall [DIM+1];
   csr_wr_type        csr_wr;
   q16_type [DIM-1:0] rsp_vec;

   assign csr_wr.we    = csr_we;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   // Enter the vector with all row sums at zero.
   always_comb begin
      lane[0]        = '0;
      lane[0].vec[0] = req_vec_x;
      lane[0].vec[1] = req_vec_y;
      lane[0].vec[2] = req_vec_z;
      lane[0].vec[3] = req_vec_w;
   end
   assign valid[0]  = req_valid;
   assign req_stall = stall[0];

   // Cell c owns column c of the matrix and adds M[r][c] * v[c] into every row sum.
   for (genvar c = 0; c < DIM; c++) begin : g_cell
      mvt_cell #(
         .COL_IDX (c)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_wr    (csr_wr),
         .in_valid  (valid[c]),
         .in_stall  (stall[c]),
         .in_lane   (lane[c]),
         .out_valid (valid[c+1]),
         .out_stall (stall[c+1]),
         .out_lane  (lane[c+1])
      );
   end

   // Drop the fraction bits, clamp, and hold the word for the consumer.
   mvt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[DIM]),
      .in_stall  (stall[DIM]),
      .in_lane   (lane[DIM]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_vec   (rsp_vec)
   );

   assign rsp_out_x = rsp_vec[0];
   assign rsp_out_y = rsp_vec[1];
   assign rsp_out_z = rsp_vec[2];
   assign rsp_out_w = rsp_vec[3];

endmodule

### rtl/mvt_checker.sv
// Port-level checks for the matrix-vector transform, bound to its top level.
module mvt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input mvt_pkg::q16_type                rsp_out_x,
   input mvt_pkg::q16_type                rsp_out_y,
   input mvt_pkg::q16_type                rsp_out_z,
   input mvt_pkg::q16_type                rsp_out_w
);
   import mvt_pkg::*;

   localparam int OCC_W = $clog2(LATENCY + 1);

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Track words inside the block.
   always_comb begin
      occ_in = occ_ff;
      if (req_take && !rsp_take) begin
         occ_in = occ_ff + 1'b1;
      end else if (!req_take && rsp_take) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
                                 && $stable(rsp_out_z) && $stable(rsp_out_w))
      else $error("result word changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result word without a pending input word");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(LATENCY))
      else $error("more words in flight than pipeline stages");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && occ_ff == OCC_W'(LATENCY))
      else $error("input stalled while the pipeline has room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind matrix_vector_transform mvt_checker u_mvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_out_x (rsp_out_x),
   .rsp_out_y (rsp_out_y),
   .rsp_out_z (rsp_out_z),
   .rsp_out_w (rsp_out_w)
);
